// File: sv/rst_pkg.sv
// Shared types, codes and widths for the ranked score table.
package rst_pkg;

   localparam int ID_W          = 6;
   localparam int COUNT_W       = 5;
   localparam int SCORE_IN_W    = 32;
   localparam int TOP_SLOTS     = 4;
   localparam int RANK_SLOTS    = 5;
   localparam int CAPACITY_DEF  = 16;
   localparam int SCORE_BITS_DEF = 32;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_UPDATE = 2'd1,
      OP_REMOVE = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ERR_OK   = 2'd0,
      ERR_FULL = 2'd1,
      ERR_MISS = 2'd2,
      ERR_DUP  = 2'd3
   } err_type;

   typedef struct packed {
      logic [RANK_SLOTS-1:0][ID_W-1:0] rank_ids;
      logic [COUNT_W-1:0]              entry_count;
      logic                            in_top_four;
      err_type                         error_code;
   } rsp_type;

endpackage

// File: sv/rst_store.sv
// Single-port-read, single-port-write table of ids and scores in rank order.
module rst_store
   import rst_pkg::*;
#(
   parameter int DEPTH = CAPACITY_DEF,
   parameter int AW    = $clog2(CAPACITY_DEF),
   parameter int SW    = SCORE_BITS_DEF
) (
   input  logic                 clock,
   input  logic [AW-1:0]        rd_addr,
   output logic [ID_W-1:0]      rd_id,
   output logic signed [SW-1:0] rd_score,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  logic [ID_W-1:0]      wr_id,
   input  logic signed [SW-1:0] wr_score
);

   logic [ID_W-1:0]      id_mem_ff    [DEPTH];
   logic signed [SW-1:0] score_mem_ff [DEPTH];
   logic [ID_W-1:0]      rd_id_ff;
   logic signed [SW-1:0] rd_score_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         id_mem_ff[wr_addr]    <= wr_id;
         score_mem_ff[wr_addr] <= wr_score;
      end
      rd_id_ff    <= id_mem_ff[rd_addr];
      rd_score_ff <= score_mem_ff[rd_addr];
   end

   assign rd_id    = rd_id_ff;
   assign rd_score = rd_score_ff;

endmodule

// File: sv/rst_ctrl.sv
// Sequencer: search, bubble-insert, remove-shift and rank readout over the table.
module rst_ctrl
   import rst_pkg::*;
#(
   parameter int CAPACITY   = CAPACITY_DEF,
   parameter int SCORE_BITS = SCORE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [1:0]            opcode,
   input  logic [ID_W-1:0]       entry_id,
   input  logic [SCORE_IN_W-1:0] score,
   input  logic                  rsp_free,
   output logic                  idle,
   output logic                  done,
   output rsp_type               result
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int SW = (SCORE_BITS > SCORE_IN_W) ? SCORE_IN_W : SCORE_BITS;

   typedef enum logic [12:0] {
      ST_IDLE     = 13'b0000000000001,
      ST_SRCH_RD  = 13'b0000000000010,
      ST_SRCH_CMP = 13'b0000000000100,
      ST_DECIDE   = 13'b0000000001000,
      ST_UP_RD    = 13'b0000000010000,
      ST_UP_CMP   = 13'b0000000100000,
      ST_DN_RD    = 13'b0000001000000,
      ST_DN_CMP   = 13'b0000010000000,
      ST_RM_RD    = 13'b0000100000000,
      ST_RM_WR    = 13'b0001000000000,
      ST_OUT_RD   = 13'b0010000000000,
      ST_OUT_CAP  = 13'b0100000000000,
      ST_DONE     = 13'b1000000000000
   } state_type;

   state_type                       state_ff, state_in;
   logic [CW-1:0]                   cnt_ff, cnt_in;
   logic [CW-1:0]                   idx_ff, idx_in;
   logic [AW-1:0]                   pos_ff, pos_in;
   logic                            found_ff, found_in;
   logic                            intop_ff, intop_in;
   err_type                         err_ff, err_in;
   logic [1:0]                      op_ff, op_in;
   logic [ID_W-1:0]                 id_ff, id_in;
   logic signed [SW-1:0]            key_ff, key_in;
   logic [RANK_SLOTS-1:0][ID_W-1:0] rank_ff, rank_in;

   logic [AW-1:0]        rd_addr;
   logic [ID_W-1:0]      rd_id;
   logic signed [SW-1:0] rd_score;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [ID_W-1:0]      wr_id;
   logic signed [SW-1:0] wr_score;

   rst_store #(
      .DEPTH (CAPACITY),
      .AW    (AW),
      .SW    (SW)
   ) u_store (
      .clock    (clock),
      .rd_addr  (rd_addr),
      .rd_id    (rd_id),
      .rd_score (rd_score),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_id    (wr_id),
      .wr_score (wr_score)
   );

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      pos_in   = pos_ff;
      found_in = found_ff;
      intop_in = intop_ff;
      err_in   = err_ff;
      op_in    = op_ff;
      id_in    = id_ff;
      key_in   = key_ff;
      rank_in  = rank_ff;
      rd_addr  = '0;
      wr_en    = 1'b0;
      wr_addr  = pos_ff;
      wr_id    = rd_id;
      wr_score = rd_score;
      done     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in    = opcode;
               id_in    = entry_id;
               key_in   = signed'(score[SW-1:0]);
               idx_in   = '0;
               found_in = 1'b0;
               err_in   = ERR_OK;
               state_in = (cnt_ff == '0) ? ST_DECIDE : ST_SRCH_RD;
            end
         end
         ST_SRCH_RD: begin
            rd_addr  = idx_ff[AW-1:0];
            state_in = ST_SRCH_CMP;
         end
         ST_SRCH_CMP: begin
            if (rd_id == id_ff) begin
               found_in = 1'b1;
               pos_in   = idx_ff[AW-1:0];
               state_in = ST_DECIDE;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = (idx_ff + CW'(1) == cnt_ff) ? ST_DECIDE : ST_SRCH_RD;
            end
         end
         ST_DECIDE: begin
            intop_in = found_ff && (pos_ff < TOP_SLOTS);
            state_in = ST_OUT_RD;
            idx_in   = '0;
            case (op_ff)
               OP_ADD: begin
                  if (found_ff) begin
                     err_in = ERR_DUP;
                  end else if (cnt_ff == CW'(CAPACITY)) begin
                     err_in = ERR_FULL;
                  end else begin
                     pos_in   = cnt_ff[AW-1:0];
                     cnt_in   = cnt_ff + CW'(1);
                     state_in = ST_UP_RD;
                  end
               end
               OP_UPDATE: begin
                  if (!found_ff) begin
                     err_in = ERR_MISS;
                  end else begin
                     state_in = ST_UP_RD;
                  end
               end
               OP_REMOVE: begin
                  if (!found_ff) begin
                     err_in = ERR_MISS;
                  end else begin
                     idx_in   = CW'(pos_ff);
                     state_in = ST_RM_RD;
                  end
               end
               default: ;
            endcase
         end
         ST_UP_RD: begin
            if (pos_ff == '0) begin
               state_in = ST_DN_RD;
            end else begin
               rd_addr  = pos_ff - AW'(1);
               state_in = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            if (key_ff > rd_score) begin
               wr_en    = 1'b1;
               pos_in   = pos_ff - AW'(1);
               state_in = ST_UP_RD;
            end else begin
               state_in = ST_DN_RD;
            end
         end
         ST_DN_RD: begin
            if (CW'(pos_ff) + CW'(1) >= cnt_ff) begin
               wr_en    = 1'b1;
               wr_id    = id_ff;
               wr_score = key_ff;
               intop_in = pos_ff < TOP_SLOTS;
               idx_in   = '0;
               state_in = ST_OUT_RD;
            end else begin
               rd_addr  = pos_ff + AW'(1);
               state_in = ST_DN_CMP;
            end
         end
         ST_DN_CMP: begin
            if (key_ff < rd_score) begin
               wr_en    = 1'b1;
               pos_in   = pos_ff + AW'(1);
               state_in = ST_DN_RD;
            end else begin
               wr_en    = 1'b1;
               wr_id    = id_ff;
               wr_score = key_ff;
               intop_in = pos_ff < TOP_SLOTS;
               idx_in   = '0;
               state_in = ST_OUT_RD;
            end
         end
         ST_RM_RD: begin
            if (idx_ff + CW'(1) >= cnt_ff) begin
               cnt_in   = cnt_ff - CW'(1);
               intop_in = 1'b0;
               idx_in   = '0;
               state_in = ST_OUT_RD;
            end else begin
               rd_addr  = idx_ff[AW-1:0] + AW'(1);
               state_in = ST_RM_WR;
            end
         end
         ST_RM_WR: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff[AW-1:0];
            idx_in   = idx_ff + CW'(1);
            state_in = ST_RM_RD;
         end
         ST_OUT_RD: begin
            rd_addr  = idx_ff[AW-1:0];
            state_in = ST_OUT_CAP;
         end
         ST_OUT_CAP: begin
            rank_in[idx_ff[2:0]] = (idx_ff < cnt_ff) ? rd_id : '0;
            if (idx_ff == CW'(RANK_SLOTS - 1)) begin
               state_in = ST_DONE;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = ST_OUT_RD;
            end
         end
         ST_DONE: begin
            done = 1'b1;
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      idx_ff   <= idx_in;
      pos_ff   <= pos_in;
      found_ff <= found_in;
      intop_ff <= intop_in;
      err_ff   <= err_in;
      op_ff    <= op_in;
      id_ff    <= id_in;
      key_ff   <= key_in;
      rank_ff  <= rank_in;
   end

   assign idle               = (state_ff == ST_IDLE);
   assign result.rank_ids    = rank_ff;
   assign result.entry_count = COUNT_W'(cnt_ff);
   assign result.in_top_four = intop_ff;
   assign result.error_code  = err_ff;

endmodule

// File: sv/ranked_score_table_top4.sv
// Top level of the ranked score table: request intake, sequencer and response register.
//
//   channel  | ports                                   | direction
//   ---------+-----------------------------------------+----------
//   req      | req_valid, req_stall, opcode/id/score   | in
//   rsp      | rsp_valid, rsp_stall, ranks/count/flags | out
//
// The length of one transaction grows with the entries searched and the places moved or shifted,
// all set by the single read port of the table memory walked by the sequencer.
// Reset clears the entry count, sequencer state and response valid flag; table contents are never cleared.
// A held response does not block the next request; the sequencer waits at its end
// until the response register is free.
module ranked_score_table_top4
   import rst_pkg::*;
#(
   parameter int CAPACITY   = CAPACITY_DEF,
   parameter int SCORE_BITS = SCORE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_opcode,
   input  logic [ID_W-1:0]       req_entry_id,
   input  logic [SCORE_IN_W-1:0] req_score,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [ID_W-1:0]       rsp_rank0_id,
   output logic [ID_W-1:0]       rsp_rank1_id,
   output logic [ID_W-1:0]       rsp_rank2_id,
   output logic [ID_W-1:0]       rsp_rank3_id,
   output logic [ID_W-1:0]       rsp_rank4_id,
   output logic [COUNT_W-1:0]    rsp_entry_count,
   output logic                  rsp_in_top_four,
   output logic [1:0]            rsp_error_code
);

   logic    ctrl_idle;
   logic    ctrl_done;
   logic    rsp_free;
   logic    start;
   rsp_type ctrl_result;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;

   assign req_stall = !ctrl_idle;
   assign start     = req_valid && ctrl_idle;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   rst_ctrl #(
      .CAPACITY   (CAPACITY),
      .SCORE_BITS (SCORE_BITS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .opcode   (req_opcode),
      .entry_id (req_entry_id),
      .score    (req_score),
      .rsp_free (rsp_free),
      .idle     (ctrl_idle),
      .done     (ctrl_done),
      .result   (ctrl_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= ctrl_done;
      end
      if (ctrl_done && rsp_free) begin
         rsp_ff <= ctrl_result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_rank0_id    = rsp_ff.rank_ids[0];
   assign rsp_rank1_id    = rsp_ff.rank_ids[1];
   assign rsp_rank2_id    = rsp_ff.rank_ids[2];
   assign rsp_rank3_id    = rsp_ff.rank_ids[3];
   assign rsp_rank4_id    = rsp_ff.rank_ids[4];
   assign rsp_entry_count = rsp_ff.entry_count;
   assign rsp_in_top_four = rsp_ff.in_top_four;
   assign rsp_error_code  = rsp_ff.error_code;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("accepted transaction did not occupy the sequencer");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error_code == ERR_FULL) |-> (rsp_entry_count == COUNT_W'(CAPACITY)))
      else $error("table-full error reported below capacity");

   a_top_needs_entry: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_in_top_four) |-> (rsp_entry_count != '0))
      else $error("top-four flag with an empty table");

   a_done_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      ctrl_done |-> !ctrl_idle)
      else $error("sequencer finished while idle");

endmodule
